/* rtl/core/per_user_buffer_report_window_average_assert.svh */
// Assertion macros for the RTL file that checks its own logic.
`ifndef PER_USER_BUFFER_REPORT_WINDOW_AVERAGE_ASSERT_SVH
`define PER_USER_BUFFER_REPORT_WINDOW_AVERAGE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PUBA_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("puba: check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define PUBA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("puba: check failed one cycle later");

`endif

/* rtl/core/puba_pkg.sv */
package puba_pkg;

	localparam int NUM_USERS    = 32;
	localparam int WINDOW_DEPTH = 16;
	localparam int NUM_GROUPS   = 8;

	// fixed by the item layout
	localparam int MAX_GROUPS = 8;
	localparam int KB_SHIFT   = 10;
	localparam int UE_W       = 10;
	localparam int CNT_W      = 4;
	localparam int BYTES_W    = 32;
	localparam int REPORT_W   = 35;
	localparam int TOTAL_W    = 32;
	localparam int ACC_W      = 64;
	localparam int SAMPLE_W   = 25;
	localparam int FILL_OUT_W = 5;

	localparam int USER_IDX_W = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
	localparam int PTR_W      = $clog2(WINDOW_DEPTH);
	localparam int FILL_W     = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W      = SAMPLE_W + PTR_W;

	localparam int TREE_LEVELS = $clog2(NUM_GROUPS);
	localparam int TREE_LEAVES = 1 << TREE_LEVELS;

	// divider retires one quotient digit of DIGIT_W bits per cycle
	localparam int DIGIT_W   = 4;
	localparam int DIV_STEPS = (SUM_W + DIGIT_W - 1) / DIGIT_W;
	localparam int DIV_W     = DIV_STEPS * DIGIT_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	typedef logic [UE_W-1:0]     ue_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [BYTES_W-1:0]  bytes_t;
	typedef logic [REPORT_W-1:0] report_t;
	typedef logic [TOTAL_W-1:0]  total_t;
	typedef logic [ACC_W-1:0]    acc_t;
	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [SUM_W-1:0]    wsum_t;
	typedef logic [FILL_W-1:0]   fill_t;

endpackage

/* rtl/core/puba_in_if.sv */
interface puba_in_if
	import puba_pkg::*;
();
	logic   valid;
	logic   ready;
	ue_t    user_id;
	cnt_t   lcg_count;
	bytes_t lcg_bytes_0;
	bytes_t lcg_bytes_1;
	bytes_t lcg_bytes_2;
	bytes_t lcg_bytes_3;
	bytes_t lcg_bytes_4;
	bytes_t lcg_bytes_5;
	bytes_t lcg_bytes_6;
	bytes_t lcg_bytes_7;

	modport source (
		output valid, user_id, lcg_count,
		output lcg_bytes_0, lcg_bytes_1, lcg_bytes_2, lcg_bytes_3,
		output lcg_bytes_4, lcg_bytes_5, lcg_bytes_6, lcg_bytes_7,
		input  ready
	);
	modport sink (
		input  valid, user_id, lcg_count,
		input  lcg_bytes_0, lcg_bytes_1, lcg_bytes_2, lcg_bytes_3,
		input  lcg_bytes_4, lcg_bytes_5, lcg_bytes_6, lcg_bytes_7,
		output ready
	);
endinterface

/* rtl/core/puba_out_if.sv */
interface puba_out_if
	import puba_pkg::*;
();
	logic                  valid;
	logic                  ready;
	ue_t                   user_echo;
	logic                  bad_user;
	total_t                report_total;
	acc_t                  bytes_accumulated;
	report_t               largest_report;
	sample_t               average_kb;
	logic [FILL_OUT_W-1:0] window_fill;

	modport source (
		output valid, user_echo, bad_user, report_total, bytes_accumulated,
		output largest_report, average_kb, window_fill,
		input  ready
	);
	modport sink (
		input  valid, user_echo, bad_user, report_total, bytes_accumulated,
		input  largest_report, average_kb, window_fill,
		output ready
	);
endinterface

/* rtl/core/puba_lane.sv */
module puba_lane
	import puba_pkg::*;
(
	input  logic   clk,
	input  logic   load,
	input  logic   en,
	input  bytes_t bytes,
	output bytes_t value_s1
);

	// groups beyond the reported count contribute nothing
	always_ff @(posedge clk) begin
		if (load) begin
			value_s1 <= en ? bytes : '0;
		end
	end

endmodule

/* rtl/core/puba_merge.sv */
module puba_merge
	import puba_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    go,
	input  bytes_t  lane [NUM_GROUPS],
	output report_t sum,
	output logic    done
);

	report_t leaf [TREE_LEAVES];

	for (genvar i = 0; i < TREE_LEAVES; i++) begin : g_leaf
		if (i < NUM_GROUPS) begin : g_used
			assign leaf[i] = REPORT_W'(lane[i]);
		end else begin : g_pad
			assign leaf[i] = '0;
		end
	end

	if (TREE_LEVELS == 0) begin : g_flat
		assign sum  = leaf[0];
		assign done = go;
	end else begin : g_tree
		// heap order: node k adds children 2k and 2k+1, root at 1
		report_t                heap_s [1:TREE_LEAVES-1];
		logic [TREE_LEVELS-1:0] vld_s;

		for (genvar k = 1; k < TREE_LEAVES; k++) begin : g_node
			if (2 * k >= TREE_LEAVES) begin : g_bottom
				always_ff @(posedge clk) begin
					heap_s[k] <= leaf[2*k-TREE_LEAVES] + leaf[2*k+1-TREE_LEAVES];
				end
			end else begin : g_inner
				always_ff @(posedge clk) begin
					heap_s[k] <= heap_s[2*k] + heap_s[2*k+1];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= '0;
			end else begin
				vld_s[0] <= go;
				for (int i = 1; i < TREE_LEVELS; i++) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end

		assign sum  = heap_s[1];
		assign done = vld_s[TREE_LEVELS-1];
	end

endmodule

/* rtl/core/puba_div.sv */
module puba_div
	import puba_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  wsum_t   dividend,
	input  fill_t   divisor,
	output sample_t quotient,
	output logic    done
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	fill_t                rem_q;
	fill_t                dsr_q;
	logic [DIV_W-1:0]     dvd_q;
	logic [DIV_W-1:0]     quo_q;

	fill_t            rem_d;
	logic [DIV_W-1:0] dvd_d;
	logic [DIV_W-1:0] quo_d;

	// restoring division, DIGIT_W quotient bits per cycle
	always_comb begin
		logic [FILL_W:0]  trial;
		fill_t            r;
		logic [DIV_W-1:0] d;
		logic [DIV_W-1:0] q;
		r = rem_q;
		d = dvd_q;
		q = quo_q;
		for (int k = 0; k < DIGIT_W; k++) begin
			trial = {r, d[DIV_W-1]};
			d     = {d[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				r = FILL_W'(trial - {1'b0, dsr_q});
				q = {q[DIV_W-2:0], 1'b1};
			end else begin
				r = trial[FILL_W-1:0];
				q = {q[DIV_W-2:0], 1'b0};
			end
		end
		rem_d = r;
		dvd_d = d;
		quo_d = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - DIV_CNT_W'(1);
			done_q <= (cnt_q == DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= DIV_W'(dividend);
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign quotient = quo_q[SAMPLE_W-1:0];
	assign done     = done_q;

endmodule

/* rtl/core/per_user_buffer_report_window_average.sv */
// Per-user buffer report statistics with a sliding-window average.
// bsr (sink): one buffer status report per item, a user index, a group count
//   and eight group byte counts; groups at or beyond the count are ignored.
// stats (source): one result item per report: count, byte total and peak for
//   the user, plus the truncated average in kilobytes over the user's window.
// A valid user passes from accept to result through the lane registers, the
//   lane adder tree, a read of the window memory, the update, and the
//   radix-16 divider at one digit per cycle, then the output register.
// A user index beyond the table skips to S_DONE and gives an error result
//   once the output register is free.
// Reports are taken one at a time: ready is high only in S_IDLE.
// The result sits in an output register, so the next report is taken while
//   a stalled result waits; a result not taken holds the block before the
//   next result can be written.
// Reset clears all per-user counters at once; the window memory needs no
//   clearing, since an entry read is used only once the user's window is full.
`include "per_user_buffer_report_window_average_assert.svh"

module per_user_buffer_report_window_average
	import puba_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	puba_in_if.sink    bsr,
	puba_out_if.source stats
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_READ,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;

	// per-user counters
	total_t           seen_q [NUM_USERS];
	acc_t             bsum_q [NUM_USERS];
	report_t          peak_q [NUM_USERS];
	logic [PTR_W-1:0] ptr_q  [NUM_USERS];
	fill_t            fill_q [NUM_USERS];
	wsum_t            rsum_q [NUM_USERS];

	// window memory
	sample_t ring_mem_q [NUM_USERS][WINDOW_DEPTH];
	sample_t rdata_q;

	ue_t     user_q;
	logic    bad_q;
	report_t report_q;
	total_t  res_total_q;
	acc_t    res_bytes_q;
	report_t res_peak_q;
	fill_t   res_fill_q;
	logic    go_s1;

	logic                  out_valid_q;
	ue_t                   o_user_q;
	logic                  o_bad_q;
	total_t                o_total_q;
	acc_t                  o_bytes_q;
	report_t               o_peak_q;
	sample_t               o_avg_q;
	logic [FILL_OUT_W-1:0] o_fill_q;

	logic                  accept;
	logic                  bad_in;
	logic [USER_IDX_W-1:0] uidx;
	logic [PTR_W-1:0]      ptr_cur;
	fill_t                 fill_cur;
	logic                  full;
	sample_t               upd_sample;
	wsum_t                 upd_sum;
	fill_t                 upd_fill;
	logic [PTR_W-1:0]      upd_ptr;
	total_t                upd_total;
	acc_t                  upd_bytes;
	report_t               upd_peak;
	logic                  mem_rd;
	logic                  mem_wr;
	logic                  out_free;
	logic                  load_out;

	bytes_t  lcg_arr [MAX_GROUPS];
	bytes_t  lane_s1 [NUM_GROUPS];
	report_t tree_sum;
	logic    tree_done;
	sample_t div_quo;
	logic    div_done;

	assign lcg_arr[0] = bsr.lcg_bytes_0;
	assign lcg_arr[1] = bsr.lcg_bytes_1;
	assign lcg_arr[2] = bsr.lcg_bytes_2;
	assign lcg_arr[3] = bsr.lcg_bytes_3;
	assign lcg_arr[4] = bsr.lcg_bytes_4;
	assign lcg_arr[5] = bsr.lcg_bytes_5;
	assign lcg_arr[6] = bsr.lcg_bytes_6;
	assign lcg_arr[7] = bsr.lcg_bytes_7;

	assign bsr.ready = (state_q == S_IDLE);
	assign accept    = bsr.valid && bsr.ready;
	assign bad_in    = {1'b0, bsr.user_id} >= (UE_W + 1)'(NUM_USERS);

	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_lane
		puba_lane u_lane (
			.clk      (clk),
			.load     (accept),
			.en       (CNT_W'(g) < bsr.lcg_count),
			.bytes    (lcg_arr[g]),
			.value_s1 (lane_s1[g])
		);
	end

	puba_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_s1),
		.lane   (lane_s1),
		.sum    (tree_sum),
		.done   (tree_done)
	);

	assign uidx       = user_q[USER_IDX_W-1:0];
	assign ptr_cur    = ptr_q[uidx];
	assign fill_cur   = fill_q[uidx];
	assign full       = (fill_cur >= FILL_W'(WINDOW_DEPTH));
	assign upd_sample = SAMPLE_W'(report_q >> KB_SHIFT);
	// evict the oldest sample once the window is full
	assign upd_sum    = rsum_q[uidx] - (full ? SUM_W'(rdata_q) : '0) + SUM_W'(upd_sample);
	assign upd_fill   = full ? FILL_W'(WINDOW_DEPTH) : fill_cur + FILL_W'(1);
	assign upd_ptr    = (ptr_cur == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_cur + PTR_W'(1);
	assign upd_total  = seen_q[uidx] + TOTAL_W'(1);
	assign upd_bytes  = bsum_q[uidx] + ACC_W'(report_q);
	assign upd_peak   = (report_q > peak_q[uidx]) ? report_q : peak_q[uidx];

	assign mem_rd = (state_q == S_SUM) && tree_done;
	assign mem_wr = (state_q == S_READ);

	puba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_READ),
		.dividend (upd_sum),
		.divisor  (upd_fill),
		.quotient (div_quo),
		.done     (div_done)
	);

	assign out_free = !out_valid_q || stats.ready;
	assign load_out = out_free && (((state_q == S_DIV) && div_done) || (state_q == S_DONE));

	always_ff @(posedge clk) begin
		if (mem_rd) begin
			rdata_q <= ring_mem_q[uidx][ptr_cur];
		end
		if (mem_wr) begin
			ring_mem_q[uidx][ptr_cur] <= upd_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			go_s1       <= 1'b0;
			user_q      <= '0;
			bad_q       <= 1'b0;
			report_q    <= '0;
			res_total_q <= '0;
			res_bytes_q <= '0;
			res_peak_q  <= '0;
			res_fill_q  <= '0;
			out_valid_q <= 1'b0;
			o_user_q    <= '0;
			o_bad_q     <= 1'b0;
			o_total_q   <= '0;
			o_bytes_q   <= '0;
			o_peak_q    <= '0;
			o_avg_q     <= '0;
			o_fill_q    <= '0;
			for (int i = 0; i < NUM_USERS; i++) begin
				seen_q[i] <= '0;
				bsum_q[i] <= '0;
				peak_q[i] <= '0;
				ptr_q[i]  <= '0;
				fill_q[i] <= '0;
				rsum_q[i] <= '0;
			end
		end else begin
			// only a valid user starts the adder tree
			go_s1 <= accept && !bad_in;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						user_q  <= bsr.user_id;
						bad_q   <= bad_in;
						state_q <= bad_in ? S_DONE : S_SUM;
					end
				end
				S_SUM: begin
					if (tree_done) begin
						report_q <= tree_sum;
						state_q  <= S_READ;
					end
				end
				S_READ: begin
					seen_q[uidx] <= upd_total;
					bsum_q[uidx] <= upd_bytes;
					peak_q[uidx] <= upd_peak;
					ptr_q[uidx]  <= upd_ptr;
					fill_q[uidx] <= upd_fill;
					rsum_q[uidx] <= upd_sum;
					res_total_q  <= upd_total;
					res_bytes_q  <= upd_bytes;
					res_peak_q   <= upd_peak;
					res_fill_q   <= upd_fill;
					state_q      <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= out_free ? S_IDLE : S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (load_out) begin
				out_valid_q <= 1'b1;
				o_user_q    <= user_q;
				o_bad_q     <= bad_q;
				o_total_q   <= bad_q ? '0 : res_total_q;
				o_bytes_q   <= bad_q ? '0 : res_bytes_q;
				o_peak_q    <= bad_q ? '0 : res_peak_q;
				o_avg_q     <= bad_q ? '0 : div_quo;
				o_fill_q    <= bad_q ? '0 : FILL_OUT_W'(res_fill_q);
			end else if (stats.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stats.valid             = out_valid_q;
	assign stats.user_echo         = o_user_q;
	assign stats.bad_user          = o_bad_q;
	assign stats.report_total      = o_total_q;
	assign stats.bytes_accumulated = o_bytes_q;
	assign stats.largest_report    = o_peak_q;
	assign stats.average_kb        = o_avg_q;
	assign stats.window_fill       = o_fill_q;

	`PUBA_ASSERT_NOW(a_tree_in_sum, clk, arst_n, tree_done, state_q == S_SUM)
	`PUBA_ASSERT_NOW(a_div_in_div, clk, arst_n, div_done, state_q == S_DIV)
	`PUBA_ASSERT_NEXT(a_bad_skips, clk, arst_n, accept && bad_in, state_q == S_DONE)
	`PUBA_ASSERT_NOW(a_fill_nonzero, clk, arst_n, stats.valid && !stats.bad_user, stats.window_fill != '0)

endmodule

/* verif/tb_per_user_buffer_report_window_average.sv */
module tb_per_user_buffer_report_window_average
	import puba_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TIMEOUT_CYCLES = 500000;
	localparam int RANDOM_PER_PHASE = 434;
	localparam int HOLD_LEN = 400;
	localparam int SETTLE_CYCLES = 30;
	localparam int DIRECTED_ROWS = 25;
	localparam int PRINT_LIMIT = 60;

	typedef struct {
		ue_t    ue;
		cnt_t   cnt;
		bytes_t lane [MAX_GROUPS];
	} bsr_item_t;

	typedef struct {
		ue_t                   user;
		logic                  bad;
		total_t                total;
		acc_t                  bytes;
		report_t               peak;
		sample_t               avg;
		logic [FILL_OUT_W-1:0] fill;
	} stats_item_t;

	typedef struct {
		bsr_item_t   rpt;
		bit          typed;
		stats_item_t want;
	} bsr_row_t;

	logic clk = 1'b0;
	logic arst_n;

	puba_in_if  bsr_ch ();
	puba_out_if stats_ch ();

	per_user_buffer_report_window_average dut (
		.clk   (clk),
		.arst_n(arst_n),
		.bsr   (bsr_ch),
		.stats (stats_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// per-user statistics as the block should hold them
	total_t  seen_cnt [NUM_USERS];
	acc_t    byte_tot [NUM_USERS];
	report_t peak_of  [NUM_USERS];
	sample_t kb_ring  [NUM_USERS][WINDOW_DEPTH];
	int unsigned ring_wr  [NUM_USERS];
	int unsigned ring_cnt [NUM_USERS];
	wsum_t   ring_tot [NUM_USERS];

	stats_item_t stats_owed [$];

	int mismatch_count = 0;
	int print_budget = PRINT_LIMIT;
	int reports_sent = 0;
	int bad_sent = 0;
	int results_checked = 0;
	int full_window_seen = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_asked = 0;

	bsr_row_t directed [DIRECTED_ROWS];

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		mismatch_count++;
		if (print_budget > 0) begin
			print_budget--;
			$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		end
	endtask

	function automatic stats_item_t predict_stats(input bsr_item_t r);
		stats_item_t s;
		int unsigned u;
		int unsigned lanes;
		int unsigned p;
		report_t size;
		sample_t kb;
		s.user = r.ue;
		s.bad = 1'b0;
		s.total = '0;
		s.bytes = '0;
		s.peak = '0;
		s.avg = '0;
		s.fill = '0;
		if (r.ue >= NUM_USERS) begin
			s.bad = 1'b1;
			return s;
		end
		u = 32'(r.ue);
		lanes = (r.cnt > NUM_GROUPS) ? NUM_GROUPS : 32'(r.cnt);
		size = '0;
		for (int i = 0; i < lanes; i++)
			size += REPORT_W'(r.lane[i]);
		seen_cnt[u] += TOTAL_W'(1);
		byte_tot[u] += ACC_W'(size);
		if (size > peak_of[u])
			peak_of[u] = size;
		kb = SAMPLE_W'(size >> KB_SHIFT);
		p = ring_wr[u];
		// evict the oldest sample once the window is full
		if (ring_cnt[u] == WINDOW_DEPTH)
			ring_tot[u] -= SUM_W'(kb_ring[u][p]);
		else
			ring_cnt[u]++;
		kb_ring[u][p] = kb;
		ring_tot[u] += SUM_W'(kb);
		ring_wr[u] = (p + 1) % WINDOW_DEPTH;
		s.total = seen_cnt[u];
		s.bytes = byte_tot[u];
		s.peak = peak_of[u];
		s.avg = SAMPLE_W'(32'(ring_tot[u]) / ring_cnt[u]);
		s.fill = FILL_OUT_W'(ring_cnt[u]);
		return s;
	endfunction

	function automatic bsr_item_t bsr_of(input ue_t u, input cnt_t c, input bytes_t all);
		bsr_item_t r;
		r.ue = u;
		r.cnt = c;
		foreach (r.lane[i])
			r.lane[i] = all;
		return r;
	endfunction

	function automatic stats_item_t stats_of(input ue_t u, input logic bad, input total_t t,
		input acc_t b, input report_t pk, input sample_t a, input logic [FILL_OUT_W-1:0] f);
		stats_item_t s;
		s.user = u;
		s.bad = bad;
		s.total = t;
		s.bytes = b;
		s.peak = pk;
		s.avg = a;
		s.fill = f;
		return s;
	endfunction

	function automatic bytes_t rand_lane();
		bytes_t v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2, 3: v = $urandom_range(0, 4095);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic bsr_item_t rand_report();
		bsr_item_t r;
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: r.ue = UE_W'(NUM_USERS);
				1: r.ue = '1;
				default: r.ue = UE_W'($urandom_range(NUM_USERS, (1 << UE_W) - 1));
			endcase
		end else if ($urandom_range(0, 3) != 0) begin
			// a few busy users so that windows fill and wrap
			r.ue = UE_W'($urandom_range(0, 3));
		end else begin
			r.ue = UE_W'($urandom_range(0, NUM_USERS - 1));
		end
		r.cnt = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
		foreach (r.lane[i])
			r.lane[i] = rand_lane();
		return r;
	endfunction

	task automatic send_report(input bsr_item_t r, input bit typed, input stats_item_t want);
		stats_item_t pred;
		int gap;
		bsr_ch.user_id <= r.ue;
		bsr_ch.lcg_count <= r.cnt;
		bsr_ch.lcg_bytes_0 <= r.lane[0];
		bsr_ch.lcg_bytes_1 <= r.lane[1];
		bsr_ch.lcg_bytes_2 <= r.lane[2];
		bsr_ch.lcg_bytes_3 <= r.lane[3];
		bsr_ch.lcg_bytes_4 <= r.lane[4];
		bsr_ch.lcg_bytes_5 <= r.lane[5];
		bsr_ch.lcg_bytes_6 <= r.lane[6];
		bsr_ch.lcg_bytes_7 <= r.lane[7];
		bsr_ch.valid <= 1'b1;
		@(posedge clk);
		while (!bsr_ch.ready)
			@(posedge clk);
		pred = predict_stats(r);
		stats_owed.push_back(typed ? want : pred);
		reports_sent++;
		if (r.ue >= NUM_USERS)
			bad_sent++;
		gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap != 0) begin
			bsr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_all_results();
		bsr_ch.valid <= 1'b0;
		@(posedge clk);
		while (stats_owed.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		static int hold_served = 0;
		static int hold_left = 0;
		if (hold_asked != hold_served) begin
			hold_served++;
			hold_left = HOLD_LEN;
		end
		if (hold_left != 0) begin
			hold_left--;
			stats_ch.ready <= 1'b0;
		end else begin
			stats_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		stats_item_t got;
		stats_item_t want;
		if (arst_n && stats_ch.valid && stats_ch.ready) begin
			got.user = stats_ch.user_echo;
			got.bad = stats_ch.bad_user;
			got.total = stats_ch.report_total;
			got.bytes = stats_ch.bytes_accumulated;
			got.peak = stats_ch.largest_report;
			got.avg = stats_ch.average_kb;
			got.fill = stats_ch.window_fill;
			if (stats_owed.size() == 0) begin
				flag_mismatch("result with nothing owed, user_echo", 64'(got.user), '0);
			end else begin
				want = stats_owed.pop_front();
				results_checked++;
				if (want.fill == WINDOW_DEPTH)
					full_window_seen++;
				if (got.user !== want.user)
					flag_mismatch("user_echo", 64'(got.user), 64'(want.user));
				if (got.bad !== want.bad)
					flag_mismatch("bad_user", 64'(got.bad), 64'(want.bad));
				if (got.total !== want.total)
					flag_mismatch("report_total", 64'(got.total), 64'(want.total));
				if (got.bytes !== want.bytes)
					flag_mismatch("bytes_accumulated", got.bytes, want.bytes);
				if (got.peak !== want.peak)
					flag_mismatch("largest_report", 64'(got.peak), 64'(want.peak));
				if (got.avg !== want.avg)
					flag_mismatch("average_kb", 64'(got.avg), 64'(want.avg));
				if (got.fill !== want.fill)
					flag_mismatch("window_fill", 64'(got.fill), 64'(want.fill));
			end
		end
	end

	initial begin
		#(TIMEOUT_CYCLES * 12);
		$display("timeout with %0d results still owed", stats_owed.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		stats_item_t none;
		foreach (seen_cnt[u]) begin
			seen_cnt[u] = '0;
			byte_tot[u] = '0;
			peak_of[u] = '0;
			ring_wr[u] = 0;
			ring_cnt[u] = 0;
			ring_tot[u] = '0;
		end
		none = stats_of('0, 1'b0, '0, '0, '0, '0, '0);

		arst_n <= 1'b0;
		bsr_ch.valid <= 1'b0;
		bsr_ch.user_id <= '0;
		bsr_ch.lcg_count <= '0;
		bsr_ch.lcg_bytes_0 <= '0;
		bsr_ch.lcg_bytes_1 <= '0;
		bsr_ch.lcg_bytes_2 <= '0;
		bsr_ch.lcg_bytes_3 <= '0;
		bsr_ch.lcg_bytes_4 <= '0;
		bsr_ch.lcg_bytes_5 <= '0;
		bsr_ch.lcg_bytes_6 <= '0;
		bsr_ch.lcg_bytes_7 <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no groups: counted, zero size enters the window
		directed[0].rpt = bsr_of(10'd0, 4'd0, 32'hDEAD_BEEF);
		directed[0].typed = 1'b1;
		directed[0].want = stats_of(10'd0, 1'b0, 32'd1, 64'd0, 35'd0, 25'd0, 5'd1);
		// users beyond the table
		directed[1].rpt = bsr_of(10'h3FF, 4'd8, 32'hFFFF_FFFF);
		directed[1].typed = 1'b1;
		directed[1].want = stats_of(10'h3FF, 1'b1, '0, '0, '0, '0, '0);
		directed[2].rpt = bsr_of(UE_W'(NUM_USERS), 4'd15, 32'h0);
		directed[2].typed = 1'b1;
		directed[2].want = stats_of(UE_W'(NUM_USERS), 1'b1, '0, '0, '0, '0, '0);
		// largest report, then the same with the group count saturated
		directed[3].rpt = bsr_of(10'd31, 4'd8, 32'hFFFF_FFFF);
		directed[3].typed = 1'b1;
		directed[3].want = stats_of(10'd31, 1'b0, 32'd1, 64'h7_FFFF_FFF8, 35'h7_FFFF_FFF8,
			25'h1FF_FFFF, 5'd1);
		directed[4].rpt = bsr_of(10'd31, 4'd15, 32'hFFFF_FFFF);
		directed[4].typed = 1'b1;
		directed[4].want = stats_of(10'd31, 1'b0, 32'd2, 64'hF_FFFF_FFF0, 35'h7_FFFF_FFF8,
			25'h1FF_FFFF, 5'd2);
		directed[5].rpt = bsr_of(10'd31, 4'd9, 32'h0);
		directed[5].rpt.lane[0] = 32'd1023;
		directed[5].typed = 1'b0;
		// lanes past the count carry all ones and must be ignored
		directed[6].rpt = bsr_of(10'd1, 4'd1, 32'hFFFF_FFFF);
		directed[6].rpt.lane[0] = 32'd1024;
		directed[6].typed = 1'b1;
		directed[6].want = stats_of(10'd1, 1'b0, 32'd1, 64'd1024, 35'd1024, 25'd1, 5'd1);
		directed[7].rpt = bsr_of(10'd2, 4'd4, 32'h0000_FFFF);
		directed[7].rpt.lane[0] = 32'hAAAA_AAAA;
		directed[7].rpt.lane[1] = 32'h5555_5555;
		directed[7].rpt.lane[3] = 32'h1;
		directed[7].typed = 1'b0;
		// one user past a full window so the oldest sample gets evicted
		for (int k = 8; k < DIRECTED_ROWS; k++) begin
			directed[k].rpt = bsr_of(10'd3, 4'd1, 32'hFFFF_FFFF);
			directed[k].rpt.lane[0] = 32'(k) * 32'd7000 + 32'd2048;
			directed[k].typed = 1'b0;
		end

		foreach (directed[k])
			send_report(directed[k].rpt, directed[k].typed, directed[k].want);
		wait_all_results();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 33;
					rx_stall_pct <= 67;
				end
				1: begin
					tx_idle_pct = 67;
					rx_stall_pct <= 33;
				end
				default: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 0;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// hold the receiver off while reports keep coming
				if (n == 50 && phase != 1)
					hold_asked <= hold_asked + 1;
				if (n == 200)
					wait_all_results();
				send_report(rand_report(), 1'b0, none);
			end
			wait_all_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (stats_owed.size() != 0)
			flag_mismatch("results never delivered, count", 64'(stats_owed.size()), '0);
		$display("sent %0d reports (%0d for users out of range); checked %0d results,",
			reports_sent, bad_sent, results_checked);
		$display("%0d of them over a full window, with idle and stall mixes and long hold-offs",
			full_window_seen);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
